/* rtl/core/spa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package spa_pkg;

    localparam int PROFILE_MAX_DEF = 64;
    localparam int CODE_COUNT_DEF  = 8;

    localparam int SCORE_W   = 24;
    localparam int WORD_W    = 16;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CODE_W    = 3;
    localparam int ROW_W     = 4;
    localparam int COL_W     = 6;
    localparam int POS_W     = 6;

    localparam logic [CFG_W-1:0] LEN_RESET = 7'd64;
    localparam logic [CFG_W-1:0] GAP_RESET = 7'd0;

    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GAPS   = 1'b1;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SYMBOL = 1'b1;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 24'sh7FFFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 24'sh800000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_FILL,
        ST_SCAN,
        ST_TB_ADDR,
        ST_TB_DATA
    } state_t;

    typedef enum logic [2:0] {
        OP_KEEP,
        OP_ZERO,
        OP_GAP,
        OP_DIAG,
        OP_BEST
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic signed [SCORE_W-1:0]  head;
        logic signed [SCORE_W-1:0]  prev_new;
        logic signed [SCORE_W-1:0]  prev_old;
    } pe_ctrl_t;

    // Saturating add of a score word onto a running score.
    function automatic logic signed [SCORE_W-1:0] sat_add(
        input logic signed [SCORE_W-1:0] a,
        input logic signed [WORD_W-1:0]  b
    );
        logic signed [SCORE_W:0] sum;
        sum = {a[SCORE_W-1], a} + {{(SCORE_W+1-WORD_W){b[WORD_W-1]}}, b};
        if (sum[SCORE_W] != sum[SCORE_W-1])
            return sum[SCORE_W] ? SCORE_MIN : SCORE_MAX;
        return sum[SCORE_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/core/spa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module spa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* rtl/core/spa_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module spa_cell
    import spa_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       shift,
    input  wire logic signed [SCORE_W-1:0]  d,
    output logic signed      [SCORE_W-1:0]  q
);

    logic signed [SCORE_W-1:0] score_reg;
    logic signed [SCORE_W-1:0] score_next;

    // take the neighbor's score while the ring turns, hold otherwise
    assign score_next = shift ? d : score_reg;
    assign q = score_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_reg <= '0;
        end
        else
        begin
            score_reg <= score_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/spa_pe.sv */
`timescale 1ns / 1ps
`default_nettype none
module spa_pe
    import spa_pkg::*;
(
    input  wire pe_ctrl_t                   ctrl,
    input  wire logic signed [WORD_W-1:0]   sym_word,
    input  wire logic signed [WORD_W-1:0]   gap_word,
    output logic signed      [SCORE_W-1:0]  new_score,
    output logic                            trace_bit
);

    logic signed [SCORE_W-1:0] diag;
    logic signed [SCORE_W-1:0] left;
    logic signed [SCORE_W-1:0] best;

    assign diag = sat_add(ctrl.prev_old, sym_word);
    assign left = sat_add(ctrl.prev_new, gap_word);
    assign best = (left > diag) ? left : diag;

    // gap wins only when the left cell beats the diagonal and the sum ties the best
    assign trace_bit = (ctrl.prev_new > ctrl.prev_old) && (left == best);

    always_comb
    begin
        case (ctrl.op)
            OP_KEEP: new_score = ctrl.head;
            OP_ZERO: new_score = '0;
            OP_GAP:  new_score = left;
            OP_DIAG: new_score = diag;
            OP_BEST: new_score = best;
            default: new_score = ctrl.head;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/sequence_profile_aligner_core.sv */
`timescale 1ns / 1ps
// A score load is taken while idle and does not hold the core. A symbol turns the score
// ring once; the first symbol of a sequence turns it twice (gap row, then its own row).
// A last symbol adds a turn to pick the end score, then an address and a data step per
// column. A new symbol waits until idle; the pace is set by the ring of score cells that
// passes every cell through the single add-compare unit. Reset: state, step, out valid,
// ring scores and symbol count clear to zero; length resets to 64, band width to 0.
`default_nettype none
module sequence_profile_aligner_core
    import spa_pkg::*;
#(
    parameter int PROFILE_MAX = PROFILE_MAX_DEF,
    parameter int CODE_COUNT  = CODE_COUNT_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration
    input  wire logic                        cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]            cfg_data,
    // input items
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        cmd,
    input  wire logic [ROW_W-1:0]            profile_row,
    input  wire logic [COL_W-1:0]            profile_column,
    input  wire logic signed [WORD_W-1:0]    score_word,
    input  wire logic [CODE_W-1:0]           symbol_code,
    input  wire logic                        last_symbol,
    // result items
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [POS_W-1:0]                 position,
    output logic [CODE_W-1:0]                aligned_code,
    output logic                             is_gap,
    output logic signed [SCORE_W-1:0]        total_score,
    output logic                             last_out
);

    localparam int IW  = $clog2(PROFILE_MAX + 1);
    localparam int CAW = $clog2(PROFILE_MAX);
    localparam int SAW = $clog2(CODE_COUNT * PROFILE_MAX);
    localparam int TAW = $clog2(PROFILE_MAX * PROFILE_MAX);

    // Configuration registers
    logic [CFG_W-1:0] len_cfg_reg;
    logic [CFG_W-1:0] gap_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg <= LEN_RESET;
            gap_cfg_reg <= GAP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LENGTH: len_cfg_reg <= cfg_data;
                REG_GAPS:   gap_cfg_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Clamp the length to 1..PROFILE_MAX
    logic [IW-1:0] len;
    always_comb
    begin
        if (len_cfg_reg == '0)
            len = IW'(1);
        else if (int'(len_cfg_reg) > PROFILE_MAX)
            len = IW'(PROFILE_MAX);
        else
            len = IW'(len_cfg_reg);
    end

    // Control and datapath registers
    state_t                     state_reg,  state_next;
    logic [IW-1:0]              t_reg,      t_next;
    logic [IW-1:0]              count_reg,  count_next;
    logic [IW-1:0]              row_reg,    row_next;
    logic [IW-1:0]              i_reg,      i_next;
    logic [IW-1:0]              j_reg,      j_next;
    logic [CODE_W-1:0]          sym_reg,    sym_next;
    logic                       last_reg,   last_next;
    logic signed [SCORE_W-1:0]  pnew_reg,   pnew_next;
    logic signed [SCORE_W-1:0]  pold_reg,   pold_next;
    logic signed [SCORE_W-1:0]  cap_reg,    cap_next;
    logic signed [SCORE_W-1:0]  tot_reg,    tot_next;
    logic                       oval_reg,   oval_next;
    logic [POS_W-1:0]           pos_reg,    pos_next;
    logic [CODE_W-1:0]          code_reg,   code_next;
    logic                       ogap_reg,   ogap_next;
    logic signed [SCORE_W-1:0]  oscore_reg, oscore_next;
    logic                       olast_reg,  olast_next;

    logic in_acc;
    logic sym_acc;
    logic sweep_end;
    logic slot_free;
    logic tb_gap;
    logic sym_ok;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign sym_acc   = in_acc && (cmd == CMD_SYMBOL);
    assign sweep_end = (int'(t_reg) == PROFILE_MAX);
    assign slot_free = !oval_reg || !out_stall;
    assign sym_ok    = (int'(sym_reg) < CODE_COUNT);

    // Ring of score cells: cell 0 is the head seen by the add-compare unit,
    // the last cell takes the unit's result, so one turn visits every column.
    logic signed [SCORE_W-1:0] ring_q [PROFILE_MAX+1];
    logic signed [SCORE_W-1:0] pe_score;
    logic                      pe_trace;
    logic                      shift;

    assign shift = (state_reg == ST_INIT) || (state_reg == ST_FILL) || (state_reg == ST_SCAN);

    for (genvar k = 0; k <= PROFILE_MAX; k++)
    begin : g_ring
        logic signed [SCORE_W-1:0] d;
        if (k == PROFILE_MAX)
        begin : g_tail
            assign d = pe_score;
        end
        else
        begin : g_link
            assign d = ring_q[k+1];
        end
        spa_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .d     (d),
            .q     (ring_q[k])
        );
    end

    // Profile memories: one for symbol rows, one for the gap row
    logic                      psym_we;
    logic [SAW-1:0]            psym_waddr;
    logic [SAW-1:0]            psym_raddr;
    logic signed [WORD_W-1:0]  psym_rdata;
    logic                      pgap_we;
    logic [CAW-1:0]            pgap_raddr;
    logic signed [WORD_W-1:0]  pgap_rdata;
    logic                      col_ok;
    logic [CAW-1:0]            sweep_col;

    assign col_ok     = (int'(profile_column) < PROFILE_MAX);
    assign psym_we    = in_acc && (cmd == CMD_LOAD) && col_ok
                        && (int'(profile_row) < CODE_COUNT);
    assign pgap_we    = in_acc && (cmd == CMD_LOAD) && col_ok
                        && (int'(profile_row) == CODE_COUNT);
    assign psym_waddr = SAW'(int'(profile_row) * PROFILE_MAX + int'(profile_column));
    // issue the column needed by the next ring step
    assign sweep_col  = (int'(t_reg) < PROFILE_MAX) ? CAW'(t_reg) : '0;
    assign psym_raddr = sym_ok ? SAW'(int'(sym_reg) * PROFILE_MAX + int'(sweep_col)) : '0;
    assign pgap_raddr = sweep_col;

    spa_ram #(.WIDTH(WORD_W), .DEPTH(CODE_COUNT * PROFILE_MAX)) u_psym (
        .clk   (clk),
        .we    (psym_we),
        .waddr (psym_waddr),
        .wdata (score_word),
        .raddr (psym_raddr),
        .rdata (psym_rdata)
    );

    spa_ram #(.WIDTH(WORD_W), .DEPTH(PROFILE_MAX)) u_pgap (
        .clk   (clk),
        .we    (pgap_we),
        .waddr (CAW'(profile_column)),
        .wdata (score_word),
        .raddr (pgap_raddr),
        .rdata (pgap_rdata)
    );

    // Add-compare unit at the ring head
    pe_ctrl_t                  pe_ctrl;
    op_t                       op;
    logic signed [WORD_W-1:0]  sym_word;

    assign sym_word         = sym_ok ? psym_rdata : '0;
    assign pe_ctrl.op       = op;
    assign pe_ctrl.head     = ring_q[0];
    assign pe_ctrl.prev_new = pnew_reg;
    assign pe_ctrl.prev_old = pold_reg;

    spa_pe u_pe (
        .ctrl      (pe_ctrl),
        .sym_word  (sym_word),
        .gap_word  (pgap_rdata),
        .new_score (pe_score),
        .trace_bit (pe_trace)
    );

    // Traceback bits and symbol store
    logic              tr_we;
    logic [TAW-1:0]    tr_waddr;
    logic [TAW-1:0]    tr_raddr;
    logic              tr_rdata;
    logic [CAW-1:0]    ss_raddr;
    logic [CODE_W-1:0] ss_rdata;

    assign tr_we    = (state_reg == ST_FILL) && (op == OP_BEST);
    assign tr_waddr = TAW'((int'(row_reg) - 1) * PROFILE_MAX + int'(t_reg) - 1);
    assign tr_raddr = TAW'((int'(i_reg) - 1) * PROFILE_MAX + int'(j_reg) - 1);
    assign ss_raddr = CAW'(int'(i_reg) - 1);

    spa_ram #(.WIDTH(1), .DEPTH(PROFILE_MAX * PROFILE_MAX)) u_trace (
        .clk   (clk),
        .we    (tr_we),
        .waddr (tr_waddr),
        .wdata (pe_trace),
        .raddr (tr_raddr),
        .rdata (tr_rdata)
    );

    spa_ram #(.WIDTH(CODE_W), .DEPTH(PROFILE_MAX)) u_syms (
        .clk   (clk),
        .we    (sym_acc && (count_reg < len)),
        .waddr (CAW'(count_reg)),
        .wdata (symbol_code),
        .raddr (ss_raddr),
        .rdata (ss_rdata)
    );

    // Gap decision for the column under traceback
    assign tb_gap = (i_reg == '0)
                    || ((j_reg > i_reg)
                        && ((int'(j_reg) > int'(i_reg) + int'(gap_cfg_reg)) || tr_rdata));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sym_acc)
                begin
                    if (count_reg < len)
                        state_next = (count_reg == '0) ? ST_INIT : ST_FILL;
                    else if (last_symbol)
                        state_next = ST_SCAN;
                end
            end
            ST_INIT:
            begin
                if (sweep_end)
                    state_next = ST_FILL;
            end
            ST_FILL:
            begin
                if (sweep_end)
                    state_next = last_reg ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                if (sweep_end)
                    state_next = ST_TB_ADDR;
            end
            ST_TB_ADDR:
            begin
                state_next = ST_TB_DATA;
            end
            ST_TB_DATA:
            begin
                if (slot_free)
                    state_next = (j_reg == IW'(1)) ? ST_IDLE : ST_TB_ADDR;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Operation at the ring head
    always_comb
    begin
        op = OP_KEEP;
        case (state_reg)
            ST_INIT:
            begin
                // row zero: gaps only, up to the band edge
                if (t_reg == '0)
                    op = OP_ZERO;
                else if ((int'(t_reg) <= int'(gap_cfg_reg)) && (t_reg <= len))
                    op = OP_GAP;
            end
            ST_FILL:
            begin
                if (t_reg == row_reg)
                    op = OP_DIAG;
                else if ((t_reg > row_reg) && (t_reg <= len)
                         && (int'(t_reg) <= int'(row_reg) + int'(gap_cfg_reg)))
                    op = OP_BEST;
            end
            default:
            begin
                op = OP_KEEP;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        t_next      = t_reg;
        count_next  = count_reg;
        row_next    = row_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        sym_next    = sym_reg;
        last_next   = last_reg;
        pnew_next   = pnew_reg;
        pold_next   = pold_reg;
        cap_next    = cap_reg;
        tot_next    = tot_reg;
        oval_next   = oval_reg && out_stall;
        pos_next    = pos_reg;
        code_next   = code_reg;
        ogap_next   = ogap_reg;
        oscore_next = oscore_reg;
        olast_next  = olast_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (sym_acc)
                begin
                    sym_next  = symbol_code;
                    last_next = last_symbol;
                    row_next  = count_reg + IW'(1);
                    t_next    = '0;
                end
            end
            ST_INIT, ST_FILL, ST_SCAN:
            begin
                t_next    = sweep_end ? '0 : t_reg + IW'(1);
                pnew_next = pe_score;
                pold_next = ring_q[0];
                if ((state_reg == ST_SCAN) && (t_reg == len))
                    cap_next = ring_q[0];
                if ((state_reg == ST_FILL) && sweep_end)
                    count_next = count_reg + IW'(1);
                if ((state_reg == ST_SCAN) && sweep_end)
                begin
                    // start the walk at the end cell
                    i_next = (count_reg < len) ? count_reg : len;
                    j_next = len;
                    if (int'((count_reg < len) ? count_reg : len) + int'(gap_cfg_reg)
                        < int'(len))
                        tot_next = SCORE_MIN;
                    else
                        tot_next = cap_next;
                end
            end
            ST_TB_DATA:
            begin
                if (slot_free)
                begin
                    oval_next   = 1'b1;
                    pos_next    = POS_W'(j_reg - IW'(1));
                    code_next   = tb_gap ? '0 : ss_rdata;
                    ogap_next   = tb_gap;
                    oscore_next = tot_reg;
                    olast_next  = (j_reg == IW'(1));
                    if (!tb_gap)
                        i_next = i_reg - IW'(1);
                    j_next = j_reg - IW'(1);
                    if (j_reg == IW'(1))
                        count_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            t_reg     <= '0;
            count_reg <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            t_reg     <= t_next;
            count_reg <= count_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg    <= row_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        sym_reg    <= sym_next;
        last_reg   <= last_next;
        pnew_reg   <= pnew_next;
        pold_reg   <= pold_next;
        cap_reg    <= cap_next;
        tot_reg    <= tot_next;
        pos_reg    <= pos_next;
        code_reg   <= code_next;
        ogap_reg   <= ogap_next;
        oscore_reg <= oscore_next;
        olast_reg  <= olast_next;
    end

    assign out_valid    = oval_reg;
    assign position     = pos_reg;
    assign aligned_code = code_reg;
    assign is_gap       = ogap_reg;
    assign total_score  = oscore_reg;
    assign last_out     = olast_reg;

endmodule
`default_nettype wire

/* rtl/core/spa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module spa_checker
    import spa_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data,
    input  wire logic                      in_valid,
    input  wire logic                      in_stall,
    input  wire logic                      cmd,
    input  wire logic [ROW_W-1:0]          profile_row,
    input  wire logic [COL_W-1:0]          profile_column,
    input  wire logic signed [WORD_W-1:0]  score_word,
    input  wire logic [CODE_W-1:0]         symbol_code,
    input  wire logic                      last_symbol,
    input  wire logic                      out_valid,
    input  wire logic                      out_stall,
    input  wire logic [POS_W-1:0]          position,
    input  wire logic [CODE_W-1:0]         aligned_code,
    input  wire logic                      is_gap,
    input  wire logic signed [SCORE_W-1:0] total_score,
    input  wire logic                      last_out
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(position) && $stable(total_score))
        else $error("stalled result item changed");

    // gap columns carry no symbol
    a_gap_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_gap |-> aligned_code == '0)
        else $error("gap column carries a symbol code");

    // the closing item sits on column zero
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_out |-> position == '0)
        else $error("last item not on column zero");

    // no new input while a traceback is still emitting
    a_tb_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_out |-> in_stall)
        else $error("input taken during traceback");

endmodule

bind sequence_profile_aligner_core spa_checker u_spa_checker (.*);
`default_nettype wire
